@@ rtl/core/gjd_pkg.sv @@
package gjd_pkg;

    // Supported Gregorian year range and the base year of the day count.
    localparam logic [13:0] YEAR_MIN  = 14'd1601;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [13:0] YEAR_BASE = 14'd1600;

    // Calendar constants.
    localparam int CYCLE_DAYS  = 12053;
    localparam int CYCLE_YEARS = 33;
    localparam int GROUP_DAYS  = 1461;
    localparam int YEAR_DAYS   = 365;
    localparam int LEAP_DAYS   = 366;
    localparam int EPOCH_SHIFT = 79;
    localparam int FIRST_YEAR  = 979;
    localparam int HALF_DAYS   = 186;
    localparam int LONG_MONTH  = 31;
    localparam int SHORT_MONTH = 30;

    // Width of the day count since the base date.
    localparam int DAY_CNT_W = 22;

    // Reciprocal of 100; exact floor for every operand below 43690.
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [12:0] RECIP_100 = 13'(((64'd1 << RECIP_100_SHIFT) + 64'd99) / 64'd100);

    // Reciprocal of the cycle length; the estimate is low by at most one.
    localparam int          CYC_RECIP_SHIFT = 32;
    localparam logic [18:0] CYC_RECIP =
        19'((64'd1 << CYC_RECIP_SHIFT) / 64'(CYCLE_DAYS));

    // Fields that ride along with the date unchanged or nearly so.
    typedef struct packed {
        logic       err;
        logic [2:0] wday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } side_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } greg_t;

    typedef struct packed {
        logic [DAY_CNT_W-1:0] n;
        side_t                side;
    } days_t;

    typedef struct packed {
        logic [7:0]  cyc;
        logic [13:0] n;
        side_t       side;
    } cyc_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
        side_t       side;
    } jal_t;

    // Days before the first of each Gregorian month in a common year.
    function automatic logic [8:0] days_before(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/gjd_days.sv @@
module gjd_days (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gjd_pkg::greg_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output gjd_pkg::days_t out_data
);
    import gjd_pkg::*;

    typedef struct packed {
        logic [13:0] gy;
        logic [6:0]  c;
        logic [3:0]  mon;
        logic [4:0]  day;
        side_t       side;
    } s1_t;

    logic  s1_valid_reg;
    s1_t   s1_reg;
    s1_t   s1_next;
    logic  s1_ready;
    logic  s2_valid_reg;
    days_t s2_reg;
    days_t s2_next;
    logic  s2_ready;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    // First stage: range check, month clamp, weekday renumbering and gy / 100.
    always_comb
    begin
        logic [26:0] prod;
        s1_next.gy = in_data.year - YEAR_BASE;
        prod = 27'(s1_next.gy) * 27'(RECIP_100);
        s1_next.c = prod[RECIP_100_SHIFT +: 7];
        priority if (in_data.month == 4'd0)
            s1_next.mon = 4'd1;
        else if (in_data.month > 4'd12)
            s1_next.mon = 4'd12;
        else
            s1_next.mon = in_data.month;
        s1_next.day = in_data.day;
        s1_next.side.err = (in_data.year < YEAR_MIN) || (in_data.year > YEAR_MAX);
        priority if (in_data.wday == 3'd6)
            s1_next.side.wday = 3'd0;
        else if (in_data.wday == 3'd7)
            s1_next.side.wday = 3'd1;
        else
            s1_next.side.wday = in_data.wday + 3'd1;
        s1_next.side.hour   = in_data.hour;
        s1_next.side.minute = in_data.minute;
        s1_next.side.second = in_data.second;
    end

    // Second stage: leap rule and the day count shifted to the Jalali epoch.
    always_comb
    begin
        logic [6:0]           r100;
        logic                 nz100;
        logic                 c_lo_zero;
        logic                 leap;
        logic [DAY_CNT_W-1:0] q4;
        logic [DAY_CNT_W-1:0] q100;
        logic [DAY_CNT_W-1:0] q400;
        logic [DAY_CNT_W-1:0] extra;
        r100      = 7'(s1_reg.gy - 14'(s1_reg.c) * 14'd100);
        nz100     = (r100 != 7'd0);
        c_lo_zero = (s1_reg.c[1:0] == 2'd0);
        leap      = (s1_reg.gy[1:0] == 2'd0) && (nz100 || c_lo_zero);
        q4        = DAY_CNT_W'(s1_reg.gy[13:2]) + DAY_CNT_W'(s1_reg.gy[1:0] != 2'd0);
        q100      = DAY_CNT_W'(s1_reg.c) + DAY_CNT_W'(nz100);
        q400      = DAY_CNT_W'(s1_reg.c[6:2]) + DAY_CNT_W'(nz100 || !c_lo_zero);
        extra     = DAY_CNT_W'(leap && (s1_reg.mon > 4'd2));
        s2_next.n = DAY_CNT_W'(s1_reg.gy) * DAY_CNT_W'(YEAR_DAYS) + q4 - q100 + q400
                  + DAY_CNT_W'(days_before(s1_reg.mon)) + extra
                  + DAY_CNT_W'(s1_reg.day) - DAY_CNT_W'(EPOCH_SHIFT + 1);
        s2_next.side = s1_reg.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

endmodule

@@ rtl/core/gjd_cycle.sv @@
module gjd_cycle (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gjd_pkg::days_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output gjd_pkg::cyc_t  out_data
);
    import gjd_pkg::*;

    typedef struct packed {
        logic [DAY_CNT_W-1:0] n;
        logic [7:0]           q;
        side_t                side;
    } s3_t;

    typedef struct packed {
        logic [14:0] rem;
        logic [7:0]  q;
        side_t       side;
    } s4_t;

    logic  s3_valid_reg;
    s3_t   s3_reg;
    s3_t   s3_next;
    logic  s3_ready;
    logic  s4_valid_reg;
    s4_t   s4_reg;
    s4_t   s4_next;
    logic  s4_ready;
    logic  s5_valid_reg;
    cyc_t  s5_reg;
    cyc_t  s5_next;
    logic  s5_ready;

    assign s5_ready  = !s5_valid_reg || out_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign in_ready  = s3_ready;
    assign out_valid = s5_valid_reg;
    assign out_data  = s5_reg;

    // Estimate of the cycle number by the reciprocal of the cycle length.
    always_comb
    begin
        logic [DAY_CNT_W+18:0] prod;
        prod = (DAY_CNT_W+19)'(in_data.n) * (DAY_CNT_W+19)'(CYC_RECIP);
        s3_next.q    = prod[CYC_RECIP_SHIFT +: 8];
        s3_next.n    = in_data.n;
        s3_next.side = in_data.side;
    end

    // Remainder against the estimate; it lies below twice the cycle length.
    always_comb
    begin
        s4_next.rem  = 15'(s3_reg.n - DAY_CNT_W'(s3_reg.q) * DAY_CNT_W'(CYCLE_DAYS));
        s4_next.q    = s3_reg.q;
        s4_next.side = s3_reg.side;
    end

    // Correction step when the estimate was one short.
    always_comb
    begin
        if (s4_reg.rem >= 15'(CYCLE_DAYS))
        begin
            s5_next.cyc = s4_reg.q + 8'd1;
            s5_next.n   = 14'(s4_reg.rem - 15'(CYCLE_DAYS));
        end
        else
        begin
            s5_next.cyc = s4_reg.q;
            s5_next.n   = s4_reg.rem[13:0];
        end
        s5_next.side = s4_reg.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= in_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (s5_ready)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
            s3_reg <= s3_next;
        if (s4_ready && s3_valid_reg)
            s4_reg <= s4_next;
        if (s5_ready && s4_valid_reg)
            s5_reg <= s5_next;
    end

endmodule

@@ rtl/core/gjd_split.sv @@
module gjd_split (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gjd_pkg::cyc_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output gjd_pkg::jal_t out_data
);
    import gjd_pkg::*;

    typedef struct packed {
        logic [13:0] yb;
        logic [10:0] r;
        side_t       side;
    } s6_t;

    typedef struct packed {
        logic [13:0] y;
        logic [8:0]  n;
        side_t       side;
    } s7_t;

    logic  s6_valid_reg;
    s6_t   s6_reg;
    s6_t   s6_next;
    logic  s6_ready;
    logic  s7_valid_reg;
    s7_t   s7_reg;
    s7_t   s7_next;
    logic  s7_ready;
    logic  s8_valid_reg;
    jal_t  s8_reg;
    jal_t  s8_next;
    logic  s8_ready;

    assign s8_ready  = !s8_valid_reg || out_ready;
    assign s7_ready  = !s7_valid_reg || s8_ready;
    assign s6_ready  = !s6_valid_reg || s7_ready;
    assign in_ready  = s6_ready;
    assign out_valid = s8_valid_reg;
    assign out_data  = s8_reg;

    // Four-year groups inside the cycle, found by parallel compares.
    always_comb
    begin
        logic [3:0] g;
        g = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (in_data.n >= 14'(k * GROUP_DAYS))
                g = g + 4'd1;
        end
        s6_next.r    = 11'(in_data.n - 14'(g) * 14'(GROUP_DAYS));
        s6_next.yb   = 14'(FIRST_YEAR) + 14'(in_data.cyc) * 14'(CYCLE_YEARS)
                     + 14'({g, 2'b00});
        s6_next.side = in_data.side;
    end

    // Year within the group; the first year of a group is the long one.
    always_comb
    begin
        logic [10:0] t;
        logic [1:0]  a;
        t = s6_reg.r - 11'd1;
        a = 2'd0;
        for (int k = 1; k <= 3; k++)
        begin
            if (t >= 11'(k * YEAR_DAYS))
                a = a + 2'd1;
        end
        if (s6_reg.r >= 11'(LEAP_DAYS))
        begin
            s7_next.y = s6_reg.yb + 14'(a);
            s7_next.n = 9'(t - 11'(a) * 11'(YEAR_DAYS));
        end
        else
        begin
            s7_next.y = s6_reg.yb;
            s7_next.n = s6_reg.r[8:0];
        end
        s7_next.side = s6_reg.side;
    end

    // Month and day: six long months, then short ones.
    always_comb
    begin
        logic [3:0] m;
        logic [8:0] d;
        logic [8:0] t;
        t = s7_reg.n - 9'(HALF_DAYS);
        m = 4'd0;
        if (s7_reg.n < 9'(HALF_DAYS))
        begin
            for (int k = 1; k <= 5; k++)
            begin
                if (s7_reg.n >= 9'(k * LONG_MONTH))
                    m = m + 4'd1;
            end
            d = s7_reg.n - 9'(m) * 9'(LONG_MONTH);
        end
        else
        begin
            for (int k = 1; k <= 5; k++)
            begin
                if (t >= 9'(k * SHORT_MONTH))
                    m = m + 4'd1;
            end
            d = t - 9'(m) * 9'(SHORT_MONTH);
            m = m + 4'd6;
        end
        if (s7_reg.side.err)
        begin
            s8_next.year  = 14'd0;
            s8_next.month = 4'd0;
            s8_next.day   = 5'd0;
            s8_next.doy   = 9'd0;
        end
        else
        begin
            s8_next.year  = s7_reg.y;
            s8_next.month = m + 4'd1;
            s8_next.day   = 5'(d + 9'd1);
            s8_next.doy   = s7_reg.n + 9'd1;
        end
        s8_next.side = s7_reg.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            if (s6_ready)
                s6_valid_reg <= in_valid;
            if (s7_ready)
                s7_valid_reg <= s6_valid_reg;
            if (s8_ready)
                s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready && in_valid)
            s6_reg <= s6_next;
        if (s7_ready && s6_valid_reg)
            s7_reg <= s7_next;
        if (s8_ready && s7_valid_reg)
            s8_reg <= s8_next;
    end

endmodule

@@ rtl/core/gregorian_to_jalali_date.sv @@
// Gregorian to Jalali date converter.
// Input channel: in_valid / in_ready move one beat holding a Gregorian date,
// its weekday (Sunday = 0) and a time of day. Output channel: out_valid /
// out_ready move one beat holding the Jalali year, month, day, day of year,
// a Saturday-based weekday, the copied time and a range error flag.
// Every input beat gives exactly one output beat, in order.
// There are eight register stages from input beat to output valid: day count (2),
// division by the 33-year cycle through a reciprocal multiplier with one
// correction step (3), and the split into groups, years, months and days (3).
// Throughput is one beat per cycle while out_ready stays high.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out and a new beat is taken
// while a finished result still waits on the output register.
// When the receiver stalls, the pipeline fills and in_ready falls; nothing is
// lost or repeated. Years outside 1601 to 9999 raise range_error and give
// zero date fields. Reset empties every stage.
module gregorian_to_jalali_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [13:0] greg_year,
    input  logic [3:0]  greg_month,
    input  logic [4:0]  greg_day,
    input  logic [2:0]  greg_weekday,
    input  logic [4:0]  hour_in,
    input  logic [5:0]  minute_in,
    input  logic [5:0]  second_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] jal_year,
    output logic [3:0]  jal_month,
    output logic [4:0]  jal_day,
    output logic [8:0]  jal_day_of_year,
    output logic [2:0]  jal_weekday,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out,
    output logic        range_error
);
    import gjd_pkg::*;

    greg_t in_data;
    days_t days_data;
    logic  days_valid;
    logic  days_ready;
    cyc_t  cyc_data;
    logic  cyc_valid;
    logic  cyc_ready;
    jal_t  jal_data;

    assign in_data.year   = greg_year;
    assign in_data.month  = greg_month;
    assign in_data.day    = greg_day;
    assign in_data.wday   = greg_weekday;
    assign in_data.hour   = hour_in;
    assign in_data.minute = minute_in;
    assign in_data.second = second_in;

    // Day count since the base date.
    gjd_days u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (days_valid),
        .out_ready (days_ready),
        .out_data  (days_data)
    );

    // Split into 33-year cycles.
    gjd_cycle u_cycle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (days_valid),
        .in_ready  (days_ready),
        .in_data   (days_data),
        .out_valid (cyc_valid),
        .out_ready (cyc_ready),
        .out_data  (cyc_data)
    );

    // Year, month and day within the cycle.
    gjd_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cyc_valid),
        .in_ready  (cyc_ready),
        .in_data   (cyc_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (jal_data)
    );

    assign jal_year        = jal_data.year;
    assign jal_month       = jal_data.month;
    assign jal_day         = jal_data.day;
    assign jal_day_of_year = jal_data.doy;
    assign jal_weekday     = jal_data.side.wday;
    assign hour_out        = jal_data.side.hour;
    assign minute_out      = jal_data.side.minute;
    assign second_out      = jal_data.side.second;
    assign range_error     = jal_data.side.err;

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    import gjd_pkg::*;

    // One converted date as it leaves the block.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        err;
    } jal_date_t;

    // Scoreboard: converts each accepted date and checks the results in order.
    class date_scoreboard;

        jal_date_t expected_dates[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function int month_days(int mon, int yr);
            bit leap;
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            if (mon == 2)
                return leap ? 29 : 28;
            if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
                return 30;
            return 31;
        endfunction

        // Gregorian date to Jalali date, with the side fields carried along.
        function jal_date_t to_jalali(greg_t g);
            jal_date_t j;
            int        mon;
            int        gy;
            int        n;
            int        k;
            int        yr;
            int        mo;
            j        = '0;
            j.wday   = 3'((int'(g.wday) + 1) % 7);
            j.hour   = g.hour;
            j.minute = g.minute;
            j.second = g.second;
            j.err    = (g.year < YEAR_MIN) || (g.year > YEAR_MAX);
            if (j.err)
                return j;

            // Months outside 1 to 12 are clamped; days act as an offset.
            mon = (g.month == 4'd0) ? 1 : ((g.month > 4'd12) ? 12 : int'(g.month));
            gy  = int'(g.year) - int'(YEAR_BASE);
            n   = 365 * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
            for (k = 1; k < mon; k++)
                n += month_days(k, int'(g.year));
            n += int'(g.day) - 1 - EPOCH_SHIFT;

            // Split into 33-year cycles, 4-year groups and single years.
            yr = FIRST_YEAR + CYCLE_YEARS * (n / CYCLE_DAYS);
            n  = n % CYCLE_DAYS;
            yr += 4 * (n / GROUP_DAYS);
            n  = n % GROUP_DAYS;
            if (n >= LEAP_DAYS)
            begin
                yr += (n - 1) / YEAR_DAYS;
                n  = (n - 1) % YEAR_DAYS;
            end

            // Six months of 31 days, then months of 30 days.
            mo = 1;
            while (mo < 12 && n >= ((mo <= 6) ? LONG_MONTH : SHORT_MONTH))
            begin
                n -= (mo <= 6) ? LONG_MONTH : SHORT_MONTH;
                mo++;
            end
            j.year  = 14'(yr);
            j.month = 4'(mo);
            j.day   = 5'(n + 1);
            j.doy   = 9'((mo <= 6) ? (mo - 1) * LONG_MONTH + n + 1
                                   : HALF_DAYS + (mo - 7) * SHORT_MONTH + n + 1);
            return j;
        endfunction

        function void note_date(greg_t g);
            expected_dates.push_back(to_jalali(g));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_date(jal_date_t got);
            jal_date_t want;
            if (expected_dates.size() == 0)
            begin
                report("result beat with nothing outstanding", got.year, 0);
                return;
            end
            want = expected_dates.pop_front();
            if (got.year !== want.year)     report("jal_year", got.year, want.year);
            if (got.month !== want.month)   report("jal_month", got.month, want.month);
            if (got.day !== want.day)       report("jal_day", got.day, want.day);
            if (got.doy !== want.doy)       report("jal_day_of_year", got.doy, want.doy);
            if (got.wday !== want.wday)     report("jal_weekday", got.wday, want.wday);
            if (got.hour !== want.hour)     report("hour_out", got.hour, want.hour);
            if (got.minute !== want.minute) report("minute_out", got.minute, want.minute);
            if (got.second !== want.second) report("second_out", got.second, want.second);
            if (got.err !== want.err)       report("range_error", got.err, want.err);
        endtask

    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [13:0] greg_year = '0;
    logic [3:0]  greg_month = '0;
    logic [4:0]  greg_day = '0;
    logic [2:0]  greg_weekday = '0;
    logic [4:0]  hour_in = '0;
    logic [5:0]  minute_in = '0;
    logic [5:0]  second_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [13:0] jal_year;
    logic [3:0]  jal_month;
    logic [4:0]  jal_day;
    logic [8:0]  jal_day_of_year;
    logic [2:0]  jal_weekday;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        range_error;

    logic [7:0]     stall_tick = '0;
    jal_date_t      seen_date;
    date_scoreboard dates;

    gregorian_to_jalali_date u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .greg_year       (greg_year),
        .greg_month      (greg_month),
        .greg_day        (greg_day),
        .greg_weekday    (greg_weekday),
        .hour_in         (hour_in),
        .minute_in       (minute_in),
        .second_in       (second_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .jal_year        (jal_year),
        .jal_month       (jal_month),
        .jal_day         (jal_day),
        .jal_day_of_year (jal_day_of_year),
        .jal_weekday     (jal_weekday),
        .hour_out        (hour_out),
        .minute_out      (minute_out),
        .second_out      (second_out),
        .range_error     (range_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls step through four patterns in turn: always
    // ready, coin toss, one stall in four, and ready only one time in eight.
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_tick[7:6])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= (stall_tick[1:0] != 2'd3);
            default: out_ready <= (stall_tick[2:0] == 3'd0);
        endcase
    end

    // Every result beat is checked against the oldest outstanding date.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_date.year   = jal_year;
            seen_date.month  = jal_month;
            seen_date.day    = jal_day;
            seen_date.doy    = jal_day_of_year;
            seen_date.wday   = jal_weekday;
            seen_date.hour   = hour_out;
            seen_date.minute = minute_out;
            seen_date.second = second_out;
            seen_date.err    = range_error;
            dates.check_date(seen_date);
        end
    end

    function automatic greg_t greg_date(int y, int m, int d, int w, int h, int mi, int s);
        greg_t g;
        g.year   = 14'(y);
        g.month  = 4'(m);
        g.day    = 5'(d);
        g.wday   = 3'(w);
        g.hour   = 5'(h);
        g.minute = 6'(mi);
        g.second = 6'(s);
        return g;
    endfunction

    // Mostly well-formed dates, some near the year limits and the turns of
    // the Jalali year, and the rest raw values over every bit of each field.
    function automatic greg_t random_date();
        greg_t g;
        int    y;
        int    m;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            y = $urandom_range(1601, 9999);
            m = $urandom_range(1, 12);
            g = greg_date(y, m, $urandom_range(1, date_scoreboard::month_days(m, y)),
                          $urandom_range(0, 6), $urandom_range(0, 23),
                          $urandom_range(0, 59), $urandom_range(0, 60));
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 3))
                0:       y = $urandom_range(1595, 1640);
                1:       y = $urandom_range(9960, 10005);
                2:       y = 100 * $urandom_range(17, 99) + $urandom_range(0, 4);
                default: y = $urandom_range(1601, 9999);
            endcase
            case ($urandom_range(0, 2))
                0:       m = 3;
                1:       m = 9;
                default: m = 1 + 11 * $urandom_range(0, 1);
            endcase
            g = greg_date(y, m, $urandom_range(18, 31), $urandom_range(0, 6),
                          $urandom_range(0, 23), $urandom_range(0, 59),
                          $urandom_range(0, 60));
        end
        else
        begin
            g = greg_date($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 7),
                          $urandom_range(0, 31), $urandom_range(0, 63),
                          $urandom_range(0, 63));
        end
        return g;
    endfunction

    // Present one date beat and hold it until it is taken.
    task automatic send_date(input greg_t g);
        @(negedge clk);
        in_valid     <= 1'b1;
        greg_year    <= g.year;
        greg_month   <= g.month;
        greg_day     <= g.day;
        greg_weekday <= g.wday;
        hour_in      <= g.hour;
        minute_in    <= g.minute;
        second_in    <= g.second;
        do
            @(posedge clk);
        while (!in_ready);
        dates.note_date(g);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_all_converted();
        hold_off(1);
        while (dates.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        greg_t directed_dates[$];
        int    sent;
        int    burst;
        int    k;
        bit    drained;
        dates = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Year limits, field extremes and the clamping and rollover cases.
        directed_dates.push_back(greg_date(1601, 1, 1, 1, 0, 0, 0));
        directed_dates.push_back(greg_date(9999, 12, 31, 5, 23, 59, 60));
        directed_dates.push_back(greg_date(1600, 6, 15, 3, 12, 30, 30));
        directed_dates.push_back(greg_date(10000, 1, 1, 6, 1, 2, 3));
        directed_dates.push_back(greg_date(0, 0, 0, 0, 0, 0, 0));
        directed_dates.push_back(greg_date(16383, 15, 31, 7, 31, 63, 63));
        directed_dates.push_back(greg_date(1601, 0, 0, 0, 0, 0, 0));
        directed_dates.push_back(greg_date(9999, 15, 31, 6, 23, 59, 59));
        directed_dates.push_back(greg_date(2000, 2, 29, 2, 6, 7, 8));
        directed_dates.push_back(greg_date(2000, 3, 1, 3, 6, 7, 8));
        directed_dates.push_back(greg_date(1900, 3, 1, 4, 9, 10, 11));
        directed_dates.push_back(greg_date(2024, 3, 19, 2, 0, 0, 0));
        directed_dates.push_back(greg_date(2024, 3, 20, 3, 0, 0, 0));
        directed_dates.push_back(greg_date(2025, 3, 20, 4, 0, 0, 0));
        directed_dates.push_back(greg_date(2025, 3, 21, 5, 0, 0, 0));
        directed_dates.push_back(greg_date(2024, 9, 21, 6, 0, 0, 0));
        directed_dates.push_back(greg_date(2024, 9, 22, 0, 0, 0, 0));
        directed_dates.push_back(greg_date(2021, 2, 30, 1, 4, 5, 6));
        directed_dates.push_back(greg_date(2021, 3, 0, 2, 4, 5, 6));
        directed_dates.push_back(greg_date(2021, 13, 5, 3, 4, 5, 6));
        directed_dates.push_back(greg_date(2021, 0, 10, 7, 4, 5, 6));
        directed_dates.push_back(greg_date(2023, 12, 31, 0, 24, 60, 61));
        directed_dates.push_back(greg_date(1999, 5, 31, 7, 31, 63, 63));
        foreach (directed_dates[i])
            send_date(directed_dates[i]);
        wait_all_converted();

        // Random bursts with random gaps; once, the sender waits for a drain.
        sent    = 0;
        drained = 1'b0;
        while (sent < 1750)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst; k++)
            begin
                send_date(random_date());
                sent++;
            end
            if (sent > 900 && !drained)
            begin
                wait_all_converted();
                drained = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 8));
        end

        wait_all_converted();
        repeat (20) @(posedge clk);
        if (dates.mismatches == 0)
            $display("PASS gregorian_to_jalali_date");
        else
            $display("FAIL gregorian_to_jalali_date");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("FAIL gregorian_to_jalali_date");
        $finish;
    end

endmodule
